FILE: src/serial_register_access_master_macros.svh
// Assertion macros used by the port-level checker of the serial register access master.
// Needs clk and arst_n in scope at the point of use.
`ifndef SERIAL_REGISTER_ACCESS_MASTER_MACROS_SVH
`define SERIAL_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/srm_pkg.sv
// Package for the serial register access master: item types and constants.
// No dependencies; imported by every module of the block.
package srm_pkg;

	localparam int UnitW = 16;
	localparam int WaitW = UnitW + 1;
	localparam logic [UnitW-1:0] UNIT_TICKS_RESET = 16'd5;
	localparam logic [3:0] HDR_BITS = 4'd4;
	localparam logic [3:0] DATA_BITS = 4'd8;

	// One request item: a sequencer tick with its access request and pin input
	typedef struct packed {
		logic       start_req;
		logic       func;
		logic [2:0] reg_addr;
		logic [7:0] wr_data;
		logic       miso;
	} srm_req_t;

	// One result item: pin levels and status after the tick
	typedef struct packed {
		logic       cs_out;
		logic       sck_out;
		logic       mosi_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
	} srm_rsp_t;

endpackage

FILE: src/srm_seq.sv
// Pin-level sequencer of the serial register access master.
// Depends on srm_pkg; advances one tick for each accepted item.
module srm_seq
	import srm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [UnitW-1:0] unit_ticks,
	input  srm_req_t         req,
	output srm_rsp_t         rsp
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR_BIT, PH_HDR_HI, PH_HDR_LO, PH_HDR_END, PH_PRE,
		PH_TX_BIT, PH_TX_HI, PH_TX_LO, PH_TX_END, PH_RX_HI, PH_RX_SMP,
		PH_RX_XHI, PH_RX_XLO, PH_FIN, PH_TAIL
	} phase_t;

	phase_t           phase_q;
	logic [3:0]       bit_q;
	logic [WaitW-1:0] wait_q;
	logic [7:0]       tx_q;
	logic [7:0]       rx_q;
	logic [3:0]       hdr_q;
	logic             rd_op_q;
	logic             cs_q;
	logic             sck_q;
	logic             mosi_q;
	logic             done_q;

	logic [3:0]       bit_inc;
	logic [WaitW-1:0] short_wait;
	logic [WaitW-1:0] long_wait;

	// Delay lengths and the next bit position
	assign bit_inc    = bit_q + 4'd1;
	assign short_wait = {1'b0, unit_ticks};
	assign long_wait  = {unit_ticks, 1'b0};

	// Advance the sequencer by one tick per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			wait_q  <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			hdr_q   <= '0;
			rd_op_q <= 1'b0;
			cs_q    <= 1'b0;
			sck_q   <= 1'b0;
			mosi_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (step) begin
			done_q <= 1'b0;
			if (phase_q == PH_IDLE) begin
				if (req.start_req) begin
					rd_op_q <= req.func;
					hdr_q   <= {req.reg_addr, req.func};
					tx_q    <= req.wr_data;
					bit_q   <= '0;
					cs_q    <= 1'b1;
					wait_q  <= long_wait;
					phase_q <= PH_HDR_BIT;
				end
			end else if (wait_q != '0) begin
				wait_q <= wait_q - WaitW'(1);
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_HDR_BIT: begin
						mosi_q  <= hdr_q[bit_q[1:0]];
						wait_q  <= long_wait;
						phase_q <= PH_HDR_HI;
					end
					PH_HDR_HI: begin
						sck_q   <= 1'b1;
						wait_q  <= short_wait;
						phase_q <= PH_HDR_LO;
					end
					PH_HDR_LO: begin
						sck_q   <= 1'b0;
						wait_q  <= long_wait;
						bit_q   <= bit_inc;
						phase_q <= (bit_inc >= HDR_BITS) ? PH_HDR_END : PH_HDR_BIT;
					end
					PH_HDR_END: begin
						mosi_q  <= 1'b0;
						wait_q  <= long_wait;
						phase_q <= PH_PRE;
					end
					PH_PRE: begin
						wait_q  <= long_wait;
						bit_q   <= '0;
						phase_q <= rd_op_q ? PH_RX_HI : PH_TX_BIT;
					end
					PH_TX_BIT: begin
						mosi_q  <= tx_q[bit_q[2:0]];
						wait_q  <= long_wait;
						phase_q <= PH_TX_HI;
					end
					PH_TX_HI: begin
						sck_q   <= 1'b1;
						wait_q  <= short_wait;
						phase_q <= PH_TX_LO;
					end
					PH_TX_LO: begin
						sck_q   <= 1'b0;
						wait_q  <= long_wait;
						bit_q   <= bit_inc;
						phase_q <= (bit_inc >= DATA_BITS) ? PH_TX_END : PH_TX_BIT;
					end
					PH_TX_END: begin
						mosi_q  <= 1'b0;
						wait_q  <= long_wait;
						phase_q <= PH_FIN;
					end
					PH_RX_HI: begin
						sck_q   <= 1'b1;
						wait_q  <= long_wait;
						phase_q <= PH_RX_SMP;
					end
					PH_RX_SMP: begin
						// sample at the end of the high phase, LSB arrives first
						rx_q    <= {req.miso, rx_q[7:1]};
						sck_q   <= 1'b0;
						wait_q  <= long_wait;
						bit_q   <= bit_inc;
						phase_q <= (bit_inc >= DATA_BITS) ? PH_RX_XHI : PH_RX_HI;
					end
					PH_RX_XHI: begin
						sck_q   <= 1'b1;
						wait_q  <= long_wait;
						phase_q <= PH_RX_XLO;
					end
					PH_RX_XLO: begin
						sck_q   <= 1'b0;
						wait_q  <= '0;
						phase_q <= PH_FIN;
					end
					PH_FIN: begin
						cs_q    <= 1'b0;
						sck_q   <= 1'b1;
						wait_q  <= rd_op_q ? long_wait : short_wait;
						phase_q <= PH_TAIL;
					end
					PH_TAIL: begin
						sck_q   <= 1'b0;
						wait_q  <= '0;
						done_q  <= 1'b1;
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

	// Present the state after the last tick
	assign rsp.cs_out   = cs_q;
	assign rsp.sck_out  = sck_q;
	assign rsp.mosi_out = mosi_q;
	assign rsp.busy_res = (phase_q != PH_IDLE);
	assign rsp.done_res = done_q;
	assign rsp.rd_data  = rx_q;

endmodule

FILE: src/serial_register_access_master.sv
// Serial register access master: LSB-first bit-banged register reads and writes.
// Each request item is one sequencer tick; its result item is ready in the cycle after
// acceptance, and one item is taken every cycle while the result side keeps up.
// The sequencer state registers in srm_seq form the result register of that tick.
// Asynchronous active-low reset: idle, pins low, unit_ticks back to 5. Uses srm_pkg.
module serial_register_access_master
	import srm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [UnitW-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  srm_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output srm_rsp_t         rsp
);

	logic [UnitW-1:0] unit_ticks_q;
	logic             rsp_valid_q;
	logic             req_take;

	// Take an item when the result slot is empty or drains this cycle
	assign req_stall = rsp_valid_q & rsp_stall;
	assign req_take  = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;

	// Hold the delay unit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
		end else if (cfg_we) begin
			unit_ticks_q <= cfg_wdata;
		end
	end

	// Track an undelivered result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	srm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (req_take),
		.unit_ticks (unit_ticks_q),
		.req        (req),
		.rsp        (rsp)
	);

endmodule

FILE: src/srm_checker.sv
// Port-level checks for the serial register access master, bound to the top level.
// Depends on srm_pkg and serial_register_access_master_macros.svh.
`include "serial_register_access_master_macros.svh"

module srm_checker
	import srm_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input srm_rsp_t rsp
);

	logic req_take;
	logic rsp_wait;
	logic rsp_done;
	logic rsp_idle;
	logic frame_shut;
	logic pins_low;

	// Handshake and pin conditions seen on the ports
	assign req_take   = req_valid & ~req_stall;
	assign rsp_wait   = rsp_valid & rsp_stall;
	assign rsp_done   = rsp_valid & rsp.done_res;
	assign rsp_idle   = rsp_valid & ~rsp.busy_res;
	assign frame_shut = ~rsp.busy_res & ~rsp.cs_out & ~rsp.sck_out;
	assign pins_low   = ~rsp.cs_out & ~rsp.sck_out & ~rsp.mosi_out;

	// A stalled result item holds
	`SRM_ASSERT_NXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp), "stalled item changed")

	// Every accepted item yields a result item next cycle
	`SRM_ASSERT_NXT(a_rsp_follows, req_take, rsp_valid, "accepted item gave no result")

	// Finishing pulse comes with the frame closed and the clock low
	`SRM_ASSERT_IMP(a_done_closed, rsp_done, frame_shut, "done outside a closed frame")

	// Idle leaves every pin low; chip select only during an access
	`SRM_ASSERT_IMP(a_idle_pins, rsp_idle, pins_low, "pin active while idle")

endmodule

bind serial_register_access_master srm_checker u_srm_checker (.*);

FILE: dv/srm_access_checker.sv
`timescale 1ns / 1ps
// Checker for serial_register_access_master: follows the pin sequencer tick by tick,
// predicts every result item and compares it field by field. Depends on srm_pkg only.
module srm_access_checker
	import srm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [UnitW-1:0] cfg_wdata,
	input  logic             req_valid,
	input  logic             req_stall,
	input  srm_req_t         req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  srm_rsp_t         rsp,
	output int               fail_count,
	output int               pending,
	output logic             model_busy,
	output int               access_count
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_HDR_BIT, ST_HDR_HI, ST_HDR_LO, ST_HDR_END, ST_PRE,
		ST_TX_BIT, ST_TX_HI, ST_TX_LO, ST_TX_END,
		ST_RX_HI, ST_RX_SMP, ST_RX_XHI, ST_RX_XLO, ST_FIN, ST_TAIL
	} seq_state_t;

	// Own copy of the sequencer and its register
	logic [UnitW-1:0] unit;
	seq_state_t       st;
	logic [3:0]       bitn;
	logic [WaitW-1:0] cnt;
	logic [7:0]       tx;
	logic [7:0]       rx;
	logic [3:0]       hdr;
	logic             rd_op;
	logic             pin_cs;
	logic             pin_sck;
	logic             pin_mosi;
	int               errs;
	int               n_access;
	srm_rsp_t         tick_results_q[$];

	assign fail_count   = errs;
	assign access_count = n_access;

	function automatic logic [WaitW-1:0] short_w();
		return {1'b0, unit};
	endfunction

	function automatic logic [WaitW-1:0] long_w();
		return {unit, 1'b0};
	endfunction

	// Advance the sequencer by one tick and return the pin and status levels after it
	function automatic srm_rsp_t seq_tick(input srm_req_t it);
		srm_rsp_t r;
		logic     done;
		done = 1'b0;
		if (st == ST_IDLE) begin
			if (it.start_req) begin
				rd_op  = it.func;
				hdr    = {it.reg_addr, it.func};
				tx     = it.wr_data;
				bitn   = '0;
				pin_cs = 1'b1;
				cnt    = long_w();
				st     = ST_HDR_BIT;
				n_access++;
			end
		end else if (cnt != '0) begin
			cnt = cnt - WaitW'(1);
		end else begin
			case (st)
				ST_HDR_BIT: begin
					pin_mosi = hdr[bitn[1:0]];
					cnt = long_w();
					st = ST_HDR_HI;
				end
				ST_HDR_HI: begin
					pin_sck = 1'b1;
					cnt = short_w();
					st = ST_HDR_LO;
				end
				ST_HDR_LO: begin
					pin_sck = 1'b0;
					cnt = long_w();
					bitn = bitn + 4'd1;
					st = (bitn >= HDR_BITS) ? ST_HDR_END : ST_HDR_BIT;
				end
				ST_HDR_END: begin
					pin_mosi = 1'b0;
					cnt = long_w();
					st = ST_PRE;
				end
				ST_PRE: begin
					cnt = long_w();
					bitn = '0;
					st = rd_op ? ST_RX_HI : ST_TX_BIT;
				end
				ST_TX_BIT: begin
					pin_mosi = tx[bitn[2:0]];
					cnt = long_w();
					st = ST_TX_HI;
				end
				ST_TX_HI: begin
					pin_sck = 1'b1;
					cnt = short_w();
					st = ST_TX_LO;
				end
				ST_TX_LO: begin
					pin_sck = 1'b0;
					cnt = long_w();
					bitn = bitn + 4'd1;
					st = (bitn >= DATA_BITS) ? ST_TX_END : ST_TX_BIT;
				end
				ST_TX_END: begin
					pin_mosi = 1'b0;
					cnt = long_w();
					st = ST_FIN;
				end
				ST_RX_HI: begin
					pin_sck = 1'b1;
					cnt = long_w();
					st = ST_RX_SMP;
				end
				// sample at the end of the high phase, LSB arrives first
				ST_RX_SMP: begin
					rx = {it.miso, rx[7:1]};
					pin_sck = 1'b0;
					cnt = long_w();
					bitn = bitn + 4'd1;
					st = (bitn >= DATA_BITS) ? ST_RX_XHI : ST_RX_HI;
				end
				ST_RX_XHI: begin
					pin_sck = 1'b1;
					cnt = long_w();
					st = ST_RX_XLO;
				end
				ST_RX_XLO: begin
					pin_sck = 1'b0;
					cnt = '0;
					st = ST_FIN;
				end
				ST_FIN: begin
					pin_cs = 1'b0;
					pin_sck = 1'b1;
					cnt = rd_op ? long_w() : short_w();
					st = ST_TAIL;
				end
				default: begin
					pin_sck = 1'b0;
					cnt = '0;
					done = 1'b1;
					st = ST_IDLE;
				end
			endcase
		end
		r.cs_out   = pin_cs;
		r.sck_out  = pin_sck;
		r.mosi_out = pin_mosi;
		r.busy_res = (st != ST_IDLE);
		r.done_res = done;
		r.rd_data  = rx;
		return r;
	endfunction

	function automatic void check_field(input string nm, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", nm, want, got);
			errs++;
		end
	endfunction

	// Predict on each accepted item, compare on each accepted result
	always @(posedge clk) begin : track
		srm_rsp_t want;
		if (!arst_n) begin
			unit = UNIT_TICKS_RESET;
			st = ST_IDLE;
			bitn = '0;
			cnt = '0;
			tx = '0;
			rx = '0;
			hdr = '0;
			rd_op = 1'b0;
			pin_cs = 1'b0;
			pin_sck = 1'b0;
			pin_mosi = 1'b0;
			errs = 0;
			n_access = 0;
			tick_results_q.delete();
		end else begin
			if (req_valid && !req_stall)
				tick_results_q.push_back(seq_tick(req));
			if (rsp_valid && !rsp_stall) begin
				if (tick_results_q.size() == 0) begin
					$error("result item arrived with nothing expected");
					errs++;
				end else begin
					want = tick_results_q.pop_front();
					check_field("cs_out", 8'(want.cs_out), 8'(rsp.cs_out));
					check_field("sck_out", 8'(want.sck_out), 8'(rsp.sck_out));
					check_field("mosi_out", 8'(want.mosi_out), 8'(rsp.mosi_out));
					check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
					check_field("rd_data", want.rd_data, rsp.rd_data);
				end
			end
			if (cfg_we)
				unit = cfg_wdata;
		end
		pending    <= tick_results_q.size();
		model_busy <= (st != ST_IDLE);
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Top of the serial_register_access_master testbench: clock, reset, stimulus and verdict.
// Depends on srm_pkg, the block itself and srm_access_checker.
module tb;
	import srm_pkg::*;

	localparam logic FUNC_WR = 1'b0;
	localparam logic FUNC_RD = 1'b1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 80;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [UnitW-1:0] cfg_wdata;
	logic             req_valid;
	logic             req_stall;
	srm_req_t         req;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	srm_rsp_t         rsp;

	int   fail_count;
	int   pending;
	logic model_busy;
	int   access_count;

	bit   gaps_on = 1'b0;
	bit   stall_mode = 1'b0;
	int   hold_ticket = 0;
	int   n_ticks = 0;
	int   n_cycles = 0;

	serial_register_access_master DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	srm_access_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending      (pending),
		.model_busy   (model_busy),
		.access_count (access_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop the run if it hangs
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Result side: short random stalls, and one long hold-off when asked for
	initial begin : rsp_side
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != served) begin
				served = hold_ticket;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (stall_mode && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offer one item, with an optional gap first, and hold it until taken
	task automatic send_tick(input srm_req_t it);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		n_ticks++;
	endtask

	// Feed quiet ticks until the access in flight ends, then drain all results
	task automatic settle(input logic [7:0] mpat);
		srm_req_t it;
		int       k;
		it = '0;
		k = 0;
		do begin
			it.miso = mpat[k % 8];
			k++;
			send_tick(it);
		end while (model_busy);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_unit(input logic [UnitW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Launch one access; start stays raised for 'held' further ticks
	task automatic run_access(input logic fn, input logic [2:0] ad, input logic [7:0] wd,
	                          input logic [7:0] mpat, input int held);
		srm_req_t it;
		it.start_req = 1'b1;
		it.func      = fn;
		it.reg_addr  = ad;
		it.wr_data   = wd;
		it.miso      = mpat[0];
		send_tick(it);
		for (int i = 1; i <= held; i++) begin
			it.miso = mpat[i % 8];
			send_tick(it);
		end
		settle(mpat);
	endtask

	// Random ticks; a start that lands while idle opens a new access
	task automatic run_random(input int n, input int start_pct, input int hold_at);
		srm_req_t it;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_ticket <= hold_ticket + 1;
			it.start_req = ($urandom_range(0, 99) < start_pct);
			it.func      = 1'($urandom_range(0, 1));
			it.reg_addr  = 3'($urandom_range(0, 7));
			it.wr_data   = 8'($urandom_range(0, 255));
			it.miso      = 1'($urandom_range(0, 1));
			send_tick(it);
		end
		settle(8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero waits: directed accesses at the field extremes
		write_unit(16'd0);
		run_access(FUNC_WR, 3'd0, 8'h00, 8'h00, 0);
		run_access(FUNC_WR, 3'd7, 8'hFF, 8'hFF, 0);
		run_access(FUNC_RD, 3'd0, 8'h00, 8'hFF, 0);
		run_access(FUNC_RD, 3'd7, 8'hFF, 8'h00, 0);
		run_access(FUNC_RD, 3'd5, 8'h3C, 8'h5A, 0);
		// start held high while busy must be ignored
		run_access(FUNC_WR, 3'd2, 8'hA5, 8'hC3, 20);
		run_access(FUNC_RD, 3'd3, 8'h96, 8'h71, 20);

		// Shortest real delay, idling on both sides
		gaps_on = 1'b1;
		stall_mode <= 1'b1;
		write_unit(16'd1);
		run_random(150, 30, -1);

		// Unit set to 2, with a long hold-off on the result side
		write_unit(16'd2);
		run_random(100, 30, 30);

		// Largest setting: quiet ticks only, as an access would run far past the cycle limit
		write_unit(16'hFFFF);
		run_random(12, 0, -1);

		// Closing stretch with no idling
		gaps_on = 1'b0;
		stall_mode <= 1'b0;
		write_unit(16'd1);
		run_random(150, 30, -1);

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d ticks sent, %0d accesses launched", n_ticks, access_count);
		$display("tb: unit_ticks set to 0, 1, 2 and 65535, with stalls, gaps and a long hold");
		if (fail_count == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
